@@ rtl/two_ring_polygon_validity_check_macros.svh @@
// Assertion macros for the polygon validity check controller
`ifndef TWO_RING_POLYGON_VALIDITY_CHECK_MACROS_SVH
`define TWO_RING_POLYGON_VALIDITY_CHECK_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TRPVC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TRPVC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/trpvc_pkg.sv @@
// Shared types and codes for the polygon validity check
`timescale 1ns / 1ps

package trpvc_pkg;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ODD  = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  typedef struct packed {
    logic wr;
    logic ld;
    logic issue;
    logic dot;
    logic clr;
  } trpvc_cmd_t;

  typedef struct packed {
    logic busy;
    logic fail;
  } trpvc_sts_t;

endpackage

@@ rtl/trpvc_dp.sv @@
// Datapath: vertex memory, edge pair and turn arithmetic pipeline, fail flag
`timescale 1ns / 1ps

module trpvc_dp
  import trpvc_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 16,
  parameter int AW           = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  trpvc_cmd_t                   cmd,
  input  logic [AW-1:0]                wa,
  input  logic [AW-1:0]                ra,
  input  logic [AW-1:0]                rb,
  input  logic signed [COORD_BITS-1:0] wr_x,
  input  logic signed [COORD_BITS-1:0] wr_y,
  output trpvc_sts_t                   sts
);

  localparam int W  = COORD_BITS;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic [2*W-1:0]        mem [MAX_VERTICES];
  logic [2*W-1:0]        q0_r, q1_r;
  logic signed [W-1:0]   q0x, q0y, q1x, q1y;
  logic signed [W-1:0]   p0x_r, p0y_r, p1x_r, p1y_r;
  logic signed [DW-1:0]  s1x_r, s1y_r, s2x_r, s2y_r, dx_r, dy_r;
  logic signed [PW-1:0]  m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [SW-1:0]  den_r, ns_r, nt_r, dot_r;
  logic                  v1_r, ld1_r, dot1_r;
  logic                  v2_r, dot2_r, v3_r, dot3_r, v4_r, dot4_r;
  logic                  fail_r;
  logic                  hit;

  function automatic logic signed [DW-1:0] ext(input logic signed [W-1:0] a);
    return $signed({a[W-1], a});
  endfunction

  function automatic logic in_unit(input logic signed [SW-1:0] num,
                                   input logic signed [SW-1:0] den);
    if (!den[SW-1]) begin
      return !num[SW-1] && (num <= den);
    end
    return (num[SW-1] || (num == '0)) && (num >= den);
  endfunction

  assign q0x = $signed(q0_r[W-1:0]);
  assign q0y = $signed(q0_r[2*W-1:W]);
  assign q1x = $signed(q1_r[W-1:0]);
  assign q1y = $signed(q1_r[2*W-1:W]);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wa] <= {wr_y, wr_x};
    end
    q0_r <= mem[ra];
    q1_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (ld1_r) begin
      p0x_r <= q0x;
      p0y_r <= q0y;
      p1x_r <= q1x;
      p1y_r <= q1y;
      s1x_r <= ext(q1x) - ext(q0x);
      s1y_r <= ext(q1y) - ext(q0y);
    end
    if (dot1_r) begin
      s2y_r <= ext(q0x) - ext(p1x_r);
      s2x_r <= ext(q0y) - ext(p1y_r);
    end else begin
      s2x_r <= ext(q1x) - ext(q0x);
      s2y_r <= ext(q1y) - ext(q0y);
    end
    dx_r <= ext(p0x_r) - ext(q0x);
    dy_r <= ext(p0y_r) - ext(q0y);
    m0_r <= s1x_r * s2y_r;
    m1_r <= s2x_r * s1y_r;
    m2_r <= s1x_r * dy_r;
    m3_r <= s1y_r * dx_r;
    m4_r <= s2x_r * dy_r;
    m5_r <= s2y_r * dx_r;
    den_r <= SW'(m0_r) - SW'(m1_r);
    dot_r <= SW'(m0_r) + SW'(m1_r);
    ns_r  <= SW'(m2_r) - SW'(m3_r);
    nt_r  <= SW'(m4_r) - SW'(m5_r);
  end

  always_comb begin
    if (dot4_r) begin
      hit = dot_r[SW-1];
    end else begin
      hit = (den_r != '0) && in_unit(ns_r, den_r) && in_unit(nt_r, den_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      ld1_r  <= 1'b0;
      dot1_r <= 1'b0;
      v2_r   <= 1'b0;
      dot2_r <= 1'b0;
      v3_r   <= 1'b0;
      dot3_r <= 1'b0;
      v4_r   <= 1'b0;
      dot4_r <= 1'b0;
      fail_r <= 1'b0;
    end else begin
      v1_r   <= cmd.issue;
      ld1_r  <= cmd.ld;
      dot1_r <= cmd.issue && cmd.dot;
      v2_r   <= v1_r;
      dot2_r <= dot1_r;
      v3_r   <= v2_r;
      dot3_r <= dot2_r;
      v4_r   <= v3_r;
      dot4_r <= dot3_r;
      if (cmd.clr) begin
        fail_r <= 1'b0;
      end else if (v4_r && hit) begin
        fail_r <= 1'b1;
      end
    end
  end

  assign sts.busy = v1_r | v2_r | v3_r | v4_r | ld1_r;
  assign sts.fail = fail_r;

endmodule

@@ rtl/trpvc_ctrl.sv @@
// Controller: vertex loading, edge pair and turn sequencing, result register
`timescale 1ns / 1ps
`include "two_ring_polygon_validity_check_macros.svh"

module trpvc_ctrl
  import trpvc_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int AW           = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_last,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_valid_res,
  output logic [1:0]    out_error_code,
  output trpvc_cmd_t    cmd,
  output logic [AW-1:0] wa,
  output logic [AW-1:0] ra,
  output logic [AW-1:0] rb,
  input  trpvc_sts_t    sts
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_VERTICES);
  localparam logic [CW-1:0] ONE  = CW'(1);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_PLOAD = 7'b0000010,
    S_PAIR  = 7'b0000100,
    S_DLOAD = 7'b0001000,
    S_DOT   = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_FIN   = 7'b1000000
  } trpvc_state_t;

  trpvc_state_t  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt, h_r, h_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, ni_r, ni_nxt, a_r, a_nxt;
  logic [CW-1:0] ra_c, rb_c, wa_c, cnt_inc, nj;
  logic          ovf_r, ovf_nxt;
  logic [1:0]    err_r, err_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_valid_res_r, out_valid_res_nxt;
  logic [1:0]    out_error_code_r, out_error_code_nxt;
  logic          in_acc, full, of_now;

  function automatic logic [CW-1:0] succ(input logic [CW-1:0] i,
                                         input logic [CW-1:0] h,
                                         input logic [CW-1:0] n);
    logic [CW-1:0] ip;
    ip = i + ONE;
    if (i < h) begin
      return (ip == h) ? '0 : ip;
    end
    return (ip == n) ? h : ip;
  endfunction

  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign full     = (cnt_r == MAXC);
  assign cnt_inc  = cnt_r + (full ? '0 : ONE);
  assign of_now   = ovf_r || full;
  assign nj       = succ(j_r, h_r, n_r);

  always_comb begin
    state_nxt          = state_r;
    cnt_nxt            = cnt_r;
    ovf_nxt            = ovf_r;
    n_nxt              = n_r;
    h_nxt              = h_r;
    i_nxt              = i_r;
    j_nxt              = j_r;
    ni_nxt             = ni_r;
    a_nxt              = a_r;
    err_nxt            = err_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_valid_res_nxt  = out_valid_res_r;
    out_error_code_nxt = out_error_code_r;
    cmd                = '0;
    ra_c               = i_r;
    rb_c               = i_r;
    wa_c               = cnt_r;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cmd.wr  = !full;
          cnt_nxt = cnt_inc;
          ovf_nxt = of_now;
          if (in_last) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            n_nxt   = cnt_inc;
            h_nxt   = cnt_inc >> 1;
            i_nxt   = '0;
            if (of_now) begin
              err_nxt   = ERR_OVF;
              state_nxt = S_FIN;
            end else if (cnt_inc[0]) begin
              err_nxt   = ERR_ODD;
              state_nxt = S_FIN;
            end else begin
              err_nxt   = ERR_NONE;
              cmd.clr   = 1'b1;
              state_nxt = S_PLOAD;
            end
          end
        end
      end
      S_PLOAD: begin
        cmd.ld    = 1'b1;
        rb_c      = succ(i_r, h_r, n_r);
        ni_nxt    = succ(i_r, h_r, n_r);
        j_nxt     = i_r + ONE;
        state_nxt = S_PAIR;
      end
      S_PAIR: begin
        if (j_r == n_r) begin
          if (i_r + ONE == n_r) begin
            i_nxt     = '0;
            state_nxt = S_DLOAD;
          end else begin
            i_nxt     = i_r + ONE;
            state_nxt = S_PLOAD;
          end
        end else begin
          ra_c      = j_r;
          rb_c      = nj;
          cmd.issue = (ni_r != j_r) && (nj != i_r);
          j_nxt     = j_r + ONE;
        end
      end
      S_DLOAD: begin
        cmd.ld    = 1'b1;
        rb_c      = succ(i_r, h_r, n_r);
        a_nxt     = succ(i_r, h_r, n_r);
        state_nxt = S_DOT;
      end
      S_DOT: begin
        cmd.issue = 1'b1;
        cmd.dot   = 1'b1;
        ra_c      = succ(a_r, h_r, n_r);
        rb_c      = succ(a_r, h_r, n_r);
        if (i_r + ONE == n_r) begin
          state_nxt = S_DRAIN;
        end else begin
          i_nxt     = i_r + ONE;
          state_nxt = S_DLOAD;
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_valid_res_nxt  = (err_r == ERR_NONE) && !sts.fail;
          out_error_code_nxt = err_r;
          state_nxt          = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign wa = wa_c[AW-1:0];
  assign ra = ra_c[AW-1:0];
  assign rb = rb_c[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r              <= n_nxt;
    h_r              <= h_nxt;
    i_r              <= i_nxt;
    j_r              <= j_nxt;
    ni_r             <= ni_nxt;
    a_r              <= a_nxt;
    err_r            <= err_nxt;
    out_valid_res_r  <= out_valid_res_nxt;
    out_error_code_r <= out_error_code_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = out_valid_res_r;
  assign out_error_code = out_error_code_r;

  `TRPVC_ASSERT_IMP(a_rd_in_set, (cmd.issue || cmd.ld), (ra_c < n_r) && (rb_c < n_r), "vertex read beyond set")
  `TRPVC_ASSERT_IMP(a_no_shared, (state_r == S_PAIR) && cmd.issue, (ra_c != ni_r) && (rb_c != i_r), "adjacent edges issued as pair")
  `TRPVC_ASSERT_IMP(a_err_invalid, out_valid && (out_error_code != ERR_NONE), !out_valid_res, "error result flagged valid")
  `TRPVC_ASSERT_NXT(a_last_stops, in_valid && in_ready && in_last, !in_ready, "beat taken after last")

endmodule

@@ rtl/two_ring_polygon_validity_check.sv @@
// Top level of the two-ring polygon validity check
`timescale 1ns / 1ps

// Vertices load one beat per cycle while in_ready is high into a dual-read
// vertex memory; the beat with in_last set closes the set. An error result
// (store overflow, odd count) goes from the last beat straight to the result
// state, which registers it. Otherwise the pair sequencer reads one
// edge pair per cycle from the vertex memory's two read ports, plus one outer
// load per edge and a load and a dot step per turn test, then a five-stage
// arithmetic pipeline drains. No beat is taken during the check; loading of
// the next set proceeds while a result waits on the output port.
module two_ring_polygon_validity_check
  import trpvc_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_valid_res,
  output logic [1:0]                   out_error_code
);

  localparam int AW = $clog2(MAX_VERTICES);

  trpvc_cmd_t    cmd;
  trpvc_sts_t    sts;
  logic [AW-1:0] wa, ra, rb;

  trpvc_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .AW          (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_valid_res (out_valid_res),
    .out_error_code(out_error_code),
    .cmd           (cmd),
    .wa            (wa),
    .ra            (ra),
    .rb            (rb),
    .sts           (sts)
  );

  trpvc_dp #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS),
    .AW          (AW)
  ) u_dp (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .wa   (wa),
    .ra   (ra),
    .rb   (rb),
    .wr_x (in_x_coord),
    .wr_y (in_y_coord),
    .sts  (sts)
  );

endmodule

@@ tb/two_ring_polygon_validity_check_checker.sv @@
// Checker for the two-ring polygon validity check: predicts each verdict and compares it
`timescale 1ns / 1ps

module two_ring_polygon_validity_check_checker
  import trpvc_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic                         in_last,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_valid_res,
  input  logic [1:0]                   out_error_code,
  output int                           mismatch_count,
  output int                           results_pending
);

  typedef struct {
    logic       clean;
    logic [1:0] code;
  } verdict_t;

  verdict_t    verdict_q[$];
  longint      ring_x[MAX_VERTICES];
  longint      ring_y[MAX_VERTICES];
  int unsigned held_count       = 0;
  bit          store_overflowed = 1'b0;
  int          tally            = 0;
  int          result_no        = 0;

  function automatic int unsigned next_on_ring(input int unsigned idx, input int unsigned half);
    if (idx < half) begin
      return (idx + 1 == half) ? 0 : idx + 1;
    end
    return (idx + 1 == 2 * half) ? half : idx + 1;
  endfunction

  function automatic bit within_span(input longint num, input longint den);
    if (den > 0) begin
      return (num >= 0) && (num <= den);
    end
    return (num <= 0) && (num >= den);
  endfunction

  function automatic bit rings_clean(input int unsigned n);
    int unsigned half, i, j, ni, nj, a, b;
    longint      s1x, s1y, s2x, s2y, dx, dy, den, ns, nt, dot;
    half = n / 2;
    for (i = 0; i < n; i++) begin
      ni = next_on_ring(i, half);
      for (j = i + 1; j < n; j++) begin
        nj = next_on_ring(j, half);
        if (ni == j || nj == i) continue;
        s1x = ring_x[ni] - ring_x[i];
        s1y = ring_y[ni] - ring_y[i];
        s2x = ring_x[nj] - ring_x[j];
        s2y = ring_y[nj] - ring_y[j];
        dx  = ring_x[i] - ring_x[j];
        dy  = ring_y[i] - ring_y[j];
        den = s1x * s2y - s2x * s1y;
        if (den == 0) continue;
        ns = s1x * dy - s1y * dx;
        nt = s2x * dy - s2y * dx;
        if (within_span(ns, den) && within_span(nt, den)) return 1'b0;
      end
    end
    for (i = 0; i < n; i++) begin
      a   = next_on_ring(i, half);
      b   = next_on_ring(a, half);
      dot = (ring_x[a] - ring_x[i]) * (ring_x[b] - ring_x[a]) +
            (ring_y[a] - ring_y[i]) * (ring_y[b] - ring_y[a]);
      if (dot < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: result %0d %s: got %0d, want %0d", $realtime, result_no, what, got, want);
    tally++;
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        result_no++;
        if (verdict_q.size() == 0) begin
          report_mismatch("arrived with no verdict due, error_code", out_error_code, -1);
        end else begin
          want = verdict_q.pop_front();
          if (out_valid_res !== want.clean) begin
            report_mismatch("valid_res", out_valid_res, want.clean);
          end
          if (out_error_code !== want.code) begin
            report_mismatch("error_code", out_error_code, want.code);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (held_count < MAX_VERTICES) begin
          ring_x[held_count] = longint'(in_x_coord);
          ring_y[held_count] = longint'(in_y_coord);
          held_count++;
        end else begin
          store_overflowed = 1'b1;
        end
        if (in_last) begin
          if (store_overflowed) begin
            want.code = ERR_OVF;
          end else if (held_count[0]) begin
            want.code = ERR_ODD;
          end else begin
            want.code = ERR_NONE;
          end
          want.clean = (want.code == ERR_NONE) && rings_clean(held_count);
          verdict_q.push_back(want);
          held_count       = 0;
          store_overflowed = 1'b0;
        end
      end
    end
    mismatch_count  <= tally;
    results_pending <= verdict_q.size();
  end

endmodule

@@ tb/two_ring_polygon_validity_check_test.sv @@
// Testbench top for the two-ring polygon validity check: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module two_ring_polygon_validity_check_test;

  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 16;
  localparam int COORD_MAX    = 32767;
  localparam int COORD_MIN    = -32768;
  localparam int STALL_LIMIT  = 200000;
  localparam int TARGET_ITEMS = 900;

  typedef struct {
    int x;
    int y;
  } point_t;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] in_x_coord     = '0;
  logic signed [COORD_BITS-1:0] in_y_coord     = '0;
  logic                         in_last        = 1'b0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic                         out_valid_res;
  logic [1:0]                   out_error_code;

  int          mismatch_count;
  int          results_pending;
  point_t      set_points[$];
  int          burst_left  = 0;
  int          items_sent  = 0;
  int          idle_cycles = 0;
  logic [31:0] cycle_no    = '0;

  always #5 clk = ~clk;

  two_ring_polygon_validity_check #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_valid_res (out_valid_res),
    .out_error_code(out_error_code)
  );

  two_ring_polygon_validity_check_checker #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_valid_res  (out_valid_res),
    .out_error_code (out_error_code),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    case (cycle_no[10:9])
      2'd0: begin
        out_ready <= 1'b1;
      end
      2'd1: begin
        out_ready <= $urandom_range(0, 1);
      end
      2'd2: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_ready <= (cycle_no % 5 != 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic void push_point(input int x, input int y);
    point_t p;
    p.x = (x > COORD_MAX) ? COORD_MAX : (x < COORD_MIN) ? COORD_MIN : x;
    p.y = (y > COORD_MAX) ? COORD_MAX : (y < COORD_MIN) ? COORD_MIN : y;
    set_points.push_back(p);
  endfunction

  // convex ring of 4*q vertices, edges turning steadily anticlockwise
  function automatic void add_convex_ring(input int q, input int scale, input int sx,
                                          input int sy, input int jitter);
    int px, py, a, b, vx, vy, jx, jy;
    px = sx;
    py = sy;
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < q; k++) begin
        jx = (jitter > 0) ? rand_between(-jitter, jitter) : 0;
        jy = (jitter > 0) ? rand_between(-jitter, jitter) : 0;
        push_point(px + jx, py + jy);
        a = (q - k) * scale;
        b = k * scale;
        case (r)
          0: begin vx = a;  vy = b;  end
          1: begin vx = -b; vy = a;  end
          2: begin vx = -a; vy = -b; end
          default: begin vx = b; vy = -a; end
        endcase
        px += vx;
        py += vy;
      end
    end
  endfunction

  function automatic void add_random_points(input int count, input int cx, input int cy,
                                            input int span);
    for (int i = 0; i < count; i++) begin
      push_point(cx + rand_between(-span, span), cy + rand_between(-span, span));
    end
  endfunction

  task automatic send_vertex(input int x, input int y, input bit last_flag);
    int pause;
    if (burst_left == 0) begin
      pause      = ($urandom_range(0, 3) == 0) ? 0 : rand_between(1, 6);
      burst_left = rand_between(1, 20);
      if (pause > 0) begin
        in_valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_x_coord <= x[COORD_BITS-1:0];
    in_y_coord <= y[COORD_BITS-1:0];
    in_last    <= last_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_set();
    int n;
    n = set_points.size();
    for (int i = 0; i < n; i++) begin
      send_vertex(set_points[i].x, set_points[i].y, i == n - 1);
    end
    items_sent += (n > MAX_VERTICES) ? MAX_VERTICES : n;
    set_points.delete();
  endtask

  task automatic build_ring_pair();
    int q, smax, sa, sb, ax, ay, jitter;
    q      = ($urandom_range(0, 9) == 0) ? rand_between(5, 8) : rand_between(1, 4);
    smax   = 16000 / (q * (q + 1));
    sa     = rand_between(1, smax);
    ax     = rand_between(-10000, 10000);
    ay     = rand_between(-10000, 10000);
    jitter = ($urandom_range(0, 3) == 0) ? rand_between(1, sa) : 0;
    add_convex_ring(q, sa, ax, ay, jitter);
    case ($urandom_range(0, 2))
      0: begin
        add_convex_ring(q, rand_between(1, smax), rand_between(-10000, 10000),
                        rand_between(-10000, 10000), jitter);
      end
      1: begin
        add_convex_ring(q, rand_between(1, smax), ax + rand_between(-3000, 3000),
                        ay + rand_between(-3000, 3000), jitter);
      end
      default: begin
        sb = (sa / 3 > 0) ? sa / 3 : 1;
        add_convex_ring(q, sb, ax + sa * q * q / 3, ay + sa * q * q / 2, jitter);
      end
    endcase
  endtask

  initial begin
    int set_index, kind, n, span, dx, dy, t;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_point(COORD_MAX, COORD_MIN);
    push_point(COORD_MIN, COORD_MAX);
    send_set();
    push_point(0, 0);
    send_set();
    push_point(-1, 5);
    push_point(7, -3);
    push_point(12, 40);
    send_set();
    push_point(COORD_MIN, COORD_MIN);
    push_point(COORD_MAX, COORD_MAX);
    push_point(COORD_MIN, COORD_MAX);
    push_point(COORD_MAX, COORD_MIN);
    send_set();
    add_convex_ring(1, 1000, -20000, -20000, 0);
    add_convex_ring(1, 1000, 15000, 15000, 0);
    send_set();
    push_point(0, 0);
    push_point(400, 0);
    push_point(200, 300);
    push_point(5000, 5000);
    push_point(5400, 5000);
    push_point(5200, 5300);
    send_set();

    set_index = 0;
    while (items_sent < TARGET_ITEMS || set_index < 40) begin
      if (set_index == 12) begin
        add_convex_ring(32, rand_between(1, 12), rand_between(-8000, 0),
                        rand_between(-8000, 0), 0);
        add_convex_ring(32, rand_between(1, 6), rand_between(-8000, 8000),
                        rand_between(-8000, 8000), 0);
      end else if (set_index == 25) begin
        add_random_points(MAX_VERTICES + rand_between(1, 8), 0, 0, COORD_MAX);
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          build_ring_pair();
        end else if (kind < 70) begin
          case ($urandom_range(0, 2))
            0: span = 3;
            1: span = 100;
            default: span = COORD_MAX;
          endcase
          add_random_points(2 * rand_between(1, 8), 0, 0, span);
        end else if (kind < 80) begin
          add_random_points(2 * rand_between(0, 7) + 1, 0, 0, COORD_MAX);
        end else if (kind < 88) begin
          n = rand_between(1, 3);
          add_convex_ring(n, rand_between(10, 1000), rand_between(-10000, 10000),
                          rand_between(-10000, 10000), 0);
          add_random_points(4 * n, 0, 0, 12000);
        end else begin
          n  = 2 * rand_between(1, 4);
          dx = rand_between(-50, 50);
          dy = rand_between(-50, 50);
          for (int i = 0; i < n; i++) begin
            t = rand_between(-20, 20);
            push_point(t * dx, t * dy);
          end
        end
      end
      send_set();
      set_index++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
